// File: hw/rtl/sawq_pkg.sv
package sawq_pkg;

	// Pool and queue sizes.
	localparam int SLOT_COUNT    = 5;
	localparam int WAIT_DEPTH    = 10;
	localparam int HISTORY_DEPTH = 20;

	localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int WAIT_IDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int WAIT_CNT_W = $clog2(WAIT_DEPTH + 1);
	localparam int HIST_IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HIST_CNT_W = $clog2(HISTORY_DEPTH + 1);

	// Request codes.
	localparam logic [1:0] CMD_PARK    = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_UNDO    = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_GRANTED    = 3'd0;
	localparam logic [2:0] ST_QUEUED     = 3'd1;
	localparam logic [2:0] ST_FULL       = 3'd2;
	localparam logic [2:0] ST_RELEASED   = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
	localparam logic [2:0] ST_HIST_EMPTY = 3'd5;
	localparam logic [2:0] ST_UNDO_SKIP  = 3'd6;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] requester_id;
	} sawq_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  slot_number;
		logic [31:0] acted_id;
		logic        waiter_granted;
		logic [31:0] waiter_id;
	} sawq_out_t;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_PARK,
		OP_RELEASE,
		OP_GRANT_WAITER,
		OP_POP_HIST,
		OP_UNDO_LOAD,
		OP_UNDO_SKIP,
		OP_HIST_EMPTY,
		OP_BAD_CMD
	} sawq_op_t;

	typedef struct packed {
		logic     load;
		sawq_op_t op;
		logic     publish;
	} sawq_ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       found;
		logic       waiter_avail;
		logic       hist_empty;
		logic       pop_is_grant;
		logic       out_free;
	} sawq_sts_t;

endpackage

// File: hw/rtl/sawq_ctrl.sv
module sawq_ctrl import sawq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      ready,
	input  sawq_sts_t sts,
	output sawq_ctl_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_REL,
		S_WAITER,
		S_UNDO,
		S_PUBLISH
	} state_t;

	state_t state_q;
	state_t state_d;

	assign ready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		ctl.load    = 1'b0;
		ctl.op      = OP_NONE;
		ctl.publish = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.cmd)
					CMD_PARK: begin
						ctl.op  = OP_PARK;
						state_d = S_PUBLISH;
					end
					CMD_RELEASE: begin
						state_d = S_REL;
					end
					CMD_UNDO: begin
						if (sts.hist_empty) begin
							ctl.op  = OP_HIST_EMPTY;
							state_d = S_PUBLISH;
						end else begin
							ctl.op  = OP_POP_HIST;
							state_d = S_UNDO;
						end
					end
					default: begin
						ctl.op  = OP_BAD_CMD;
						state_d = S_PUBLISH;
					end
				endcase
			end
			S_UNDO: begin
				if (sts.pop_is_grant) begin
					ctl.op  = OP_UNDO_LOAD;
					state_d = S_REL;
				end else begin
					ctl.op  = OP_UNDO_SKIP;
					state_d = S_PUBLISH;
				end
			end
			S_REL: begin
				ctl.op  = OP_RELEASE;
				state_d = (sts.found && sts.waiter_avail) ? S_WAITER : S_PUBLISH;
			end
			S_WAITER: begin
				ctl.op  = OP_GRANT_WAITER;
				state_d = S_PUBLISH;
			end
			S_PUBLISH: begin
				if (sts.out_free) begin
					ctl.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/sawq_dp.sv
module sawq_dp import sawq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sawq_in_t  req,
	input  sawq_ctl_t ctl,
	output sawq_sts_t sts,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output sawq_out_t rsp
);

	// Slot pool.
	logic [SLOT_COUNT-1:0] slot_busy_q;
	logic [31:0]           slot_owner_q [SLOT_COUNT];

	// Wait queue and history stack.
	logic [31:0]           wait_mem [WAIT_DEPTH];
	logic [WAIT_IDX_W-1:0] wait_head_q;
	logic [WAIT_CNT_W-1:0] wait_count_q;
	logic [31:0]           wait_rd_q;
	logic [32:0]           hist_mem [HISTORY_DEPTH];
	logic [HIST_CNT_W-1:0] hist_count_q;
	logic [32:0]           hist_rd_q;

	// Current item and result.
	logic [1:0]            cmd_q;
	logic [31:0]           id_q;
	logic [SLOT_IDX_W-1:0] match_idx_q;
	sawq_out_t             res_q;
	logic                  out_valid_q;
	sawq_out_t             out_q;

	logic                  free_found;
	logic [SLOT_IDX_W-1:0] free_idx;
	logic                  match_found;
	logic [SLOT_IDX_W-1:0] match_idx;
	logic                  hist_push;
	logic [32:0]           hist_entry;
	logic                  hist_room;
	logic                  wait_room;
	logic [WAIT_CNT_W:0]   wait_sum;
	logic [WAIT_IDX_W-1:0] wait_tail;
	logic [WAIT_IDX_W-1:0] wait_head_nxt;
	logic [HIST_CNT_W-1:0] hist_top;
	logic [SLOT_IDX_W:0]   free_num;
	logic [SLOT_IDX_W:0]   match_num;

	// Lowest free slot and lowest busy slot owned by the current id.
	always_comb begin
		free_found  = 1'b0;
		free_idx    = '0;
		match_found = 1'b0;
		match_idx   = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (!slot_busy_q[i] && !free_found) begin
				free_found = 1'b1;
				free_idx   = SLOT_IDX_W'(i);
			end
			if (slot_busy_q[i] && (slot_owner_q[i] == id_q) && !match_found) begin
				match_found = 1'b1;
				match_idx   = SLOT_IDX_W'(i);
			end
		end
	end

	assign free_num  = {1'b0, free_idx} + 1'b1;
	assign match_num = {1'b0, match_idx} + 1'b1;

	assign hist_room = (hist_count_q < HIST_CNT_W'(HISTORY_DEPTH));
	assign wait_room = (wait_count_q < WAIT_CNT_W'(WAIT_DEPTH));
	assign hist_top  = hist_count_q - 1'b1;

	// The head stays below the depth and the count at most equals it, so one subtract wraps the tail.
	assign wait_sum  = (WAIT_CNT_W + 1)'(wait_head_q) + (WAIT_CNT_W + 1)'(wait_count_q);
	assign wait_tail = (wait_sum >= (WAIT_CNT_W + 1)'(WAIT_DEPTH)) ?
		WAIT_IDX_W'(wait_sum - (WAIT_CNT_W + 1)'(WAIT_DEPTH)) : WAIT_IDX_W'(wait_sum);
	assign wait_head_nxt = (wait_head_q == WAIT_IDX_W'(WAIT_DEPTH - 1)) ?
		'0 : wait_head_q + 1'b1;

	always_comb begin
		hist_push  = 1'b0;
		hist_entry = '0;
		case (ctl.op)
			OP_PARK: begin
				hist_push  = free_found;
				hist_entry = {1'b1, id_q};
			end
			OP_RELEASE: begin
				hist_push  = match_found;
				hist_entry = {1'b0, id_q};
			end
			OP_GRANT_WAITER: begin
				hist_push  = 1'b1;
				hist_entry = {1'b1, wait_rd_q};
			end
			default: begin
				hist_push = 1'b0;
			end
		endcase
	end

	assign sts.cmd          = cmd_q;
	assign sts.found        = match_found;
	assign sts.waiter_avail = (wait_count_q != '0);
	assign sts.hist_empty   = (hist_count_q == '0);
	assign sts.pop_is_grant = hist_rd_q[32];
	assign sts.out_free     = !out_valid_q || !rsp_stall;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_busy_q  <= '0;
			wait_head_q  <= '0;
			wait_count_q <= '0;
			hist_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (hist_push && hist_room) begin
				hist_count_q <= hist_count_q + 1'b1;
			end
			case (ctl.op)
				OP_PARK: begin
					if (free_found) begin
						slot_busy_q[free_idx] <= 1'b1;
					end else if (wait_room) begin
						wait_count_q <= wait_count_q + 1'b1;
					end
				end
				OP_RELEASE: begin
					if (match_found) begin
						slot_busy_q[match_idx] <= 1'b0;
					end
				end
				OP_GRANT_WAITER: begin
					slot_busy_q[match_idx_q] <= 1'b1;
					wait_head_q              <= wait_head_nxt;
					wait_count_q             <= wait_count_q - 1'b1;
				end
				OP_POP_HIST: begin
					hist_count_q <= hist_top;
				end
				default: begin
				end
			endcase
			if (ctl.publish) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload, memories and result.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= req.cmd;
			id_q  <= req.requester_id;
		end
		if (hist_push && hist_room) begin
			hist_mem[hist_count_q[HIST_IDX_W-1:0]] <= hist_entry;
		end
		if (ctl.publish) begin
			out_q <= res_q;
		end
		case (ctl.op)
			OP_PARK: begin
				if (free_found) begin
					slot_owner_q[free_idx] <= id_q;
					res_q <= '{ST_GRANTED, 3'(free_num), id_q, 1'b0, 32'd0};
				end else if (wait_room) begin
					wait_mem[wait_tail] <= id_q;
					res_q <= '{ST_QUEUED, 3'd0, id_q, 1'b0, 32'd0};
				end else begin
					res_q <= '{ST_FULL, 3'd0, id_q, 1'b0, 32'd0};
				end
			end
			OP_RELEASE: begin
				match_idx_q <= match_idx;
				wait_rd_q   <= wait_mem[wait_head_q];
				if (match_found) begin
					res_q <= '{ST_RELEASED, 3'(match_num), id_q, 1'b0, 32'd0};
				end else begin
					res_q <= '{ST_NOT_FOUND, 3'd0, id_q, 1'b0, 32'd0};
				end
			end
			OP_GRANT_WAITER: begin
				slot_owner_q[match_idx_q] <= wait_rd_q;
				res_q.waiter_granted      <= 1'b1;
				res_q.waiter_id           <= wait_rd_q;
			end
			OP_POP_HIST: begin
				hist_rd_q <= hist_mem[hist_top[HIST_IDX_W-1:0]];
			end
			OP_UNDO_LOAD: begin
				id_q <= hist_rd_q[31:0];
			end
			OP_UNDO_SKIP: begin
				res_q <= '{ST_UNDO_SKIP, 3'd0, hist_rd_q[31:0], 1'b0, 32'd0};
			end
			OP_HIST_EMPTY: begin
				res_q <= '{ST_HIST_EMPTY, 3'd0, 32'd0, 1'b0, 32'd0};
			end
			OP_BAD_CMD: begin
				res_q <= '{ST_NOT_FOUND, 3'd0, 32'd0, 1'b0, 32'd0};
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_wait_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wait_count_q <= WAIT_CNT_W'(WAIT_DEPTH))
		else $error("wait queue count beyond its depth");

	a_hist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hist_count_q <= HIST_CNT_W'(HISTORY_DEPTH))
		else $error("history count beyond its depth");

	a_waiter_present: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_GRANT_WAITER) |-> (wait_count_q != '0) && !slot_busy_q[match_idx_q])
		else $error("waiter grant without a waiter or into a busy slot");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_POP_HIST) |-> (hist_count_q != '0))
		else $error("history pop on an empty stack");

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.publish |-> (!out_valid_q || !rsp_stall))
		else $error("result overwritten before its transfer");

endmodule

// File: hw/rtl/slot_allocator_with_wait_queue.sv
// Slot allocator with a wait queue and an undo history. Each request transfer
// carries a command and a 32-bit requester id and produces exactly one result
// transfer. A park takes the lowest free slot of the pool; with no slot free
// the id joins a circular wait queue, or is dropped with the queue-full status
// when the queue is full. A release frees the lowest-numbered slot owned by
// the id and hands it straight to the head of the wait queue if one waits.
// Every grant and release is pushed onto a history stack (pushes onto a full
// stack are lost); an undo pops one entry and, for a grant, releases that id
// again, which may in turn grant the slot to a waiter. Slot numbers in the
// result count from one, and zero means no slot. The block works on one
// request at a time under a small controller. A park, an undo with empty
// history or an unused command goes from the dispatch step to the publish
// step; a release passes the release step and, when a waiter is granted,
// the separate waiter grant step with its own history push. An undo pops
// the history with a registered read and, for a grant entry, goes on to
// the release step. The wait queue head is also read into a register in
// the release step. The publish step loads the result into the output
// register and returns the controller to idle at the same edge, so the
// next request can be taken as soon as the result is offered. The result sits
// in an output register, so a new request is taken while the previous
// result waits for its transfer; no reset sweep is needed, the block is
// ready right after reset.
module slot_allocator_with_wait_queue import sawq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  sawq_in_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output sawq_out_t rsp
);

	sawq_ctl_t ctl;
	sawq_sts_t sts;
	logic      ready;

	// The controller accepts a request only in its idle state.
	assign req_stall = ~ready;

	sawq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.ready     (ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	sawq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
